// ===== src/lkv_pkg.sv =====
package lkv_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;
    logic issue;
    logic upd_phase;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic need_update;
    logic out_free;
  } sts_t;

endpackage

// ===== src/lkv_ctrl.sv =====
module lkv_ctrl
  import lkv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_UPDATE = 7'b0010000,
    S_UDRAIN = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = sts_i.need_update ? S_UPDATE : S_DONE;
      end
      S_UPDATE: begin
        cmd_o.issue = 1'b1;
        cmd_o.upd_phase = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_UDRAIN;
        end
      end
      S_UDRAIN: begin
        cmd_o.upd_phase = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A transaction is taken only after the previous result has been handed to the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN)
    else $error("accepted transaction did not start a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |-> $past(state_q == S_DRAIN))
    else $error("decision taken before the scan drained");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> in_ready_o)
    else $error("controller did not return to idle after a result");

endmodule

// ===== src/lkv_datapath.sv =====
module lkv_datapath
  import lkv_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  input  logic              operation_i,
  input  logic [DATA_W-1:0] key_i,
  input  logic [DATA_W-1:0] value_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [DATA_W-1:0] read_value_o,
  output logic              evicted_o,
  output logic [DATA_W-1:0] evicted_key_o
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;

  logic [DATA_W-1:0] keys_mem [MAX_ENTRIES];
  logic [DATA_W-1:0] vals_mem [MAX_ENTRIES];
  logic [IW-1:0]     rank_mem [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]          occ_q, occ_d;
  logic [CAP_W-1:0]       cap_q;

  logic              op_q;
  logic [DATA_W-1:0] key_q, val_q;
  logic [IW-1:0]     idx_q;

  logic              rd_vld_q;
  logic [IW-1:0]     rd_idx_q;
  logic [DATA_W-1:0] rd_key_q, rd_val_q;
  logic [IW-1:0]     rd_rank_q;

  logic              hit_q, free_found_q, any_q, evict_q;
  logic [IW-1:0]     hit_slot_q, hit_rank_q, free_slot_q, victim_slot_q, worst_q;
  logic [DATA_W-1:0] hit_val_q, victim_key_q;
  logic [IW-1:0]     slot_q, old_rank_q;

  logic              out_valid_q, out_hit_q, out_evicted_q;
  logic [DATA_W-1:0] out_read_q, out_evkey_q;

  logic          is_put, rd_entry_valid, scan_eval, upd_eval;
  logic          alloc, evict_d;
  logic [EW-1:0] cap_ext, eff_cap;
  logic [IW-1:0] slot_d, old_rank_d;
  logic          key_we, val_we, rank_we;
  logic [IW-1:0] rank_wdata;

  assign is_put = (op_q == OP_PUT);
  assign rd_entry_valid = valid_q[rd_idx_q];
  assign scan_eval = rd_vld_q && !cmd_i.upd_phase;
  assign upd_eval = rd_vld_q && cmd_i.upd_phase;

  assign cap_ext = EW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    alloc = 1'b0;
    evict_d = 1'b0;
    slot_d = hit_slot_q;
    old_rank_d = hit_rank_q;
    if (!hit_q && is_put) begin
      if (EW'(occ_q) < eff_cap) begin
        alloc = 1'b1;
        slot_d = free_slot_q;
        old_rank_d = IW'(occ_q);
      end else begin
        evict_d = 1'b1;
        slot_d = victim_slot_q;
        old_rank_d = worst_q;
      end
    end
  end

  assign key_we = cmd_i.decide && is_put && !hit_q;
  assign val_we = cmd_i.decide && is_put;

  always_comb begin
    rank_we = 1'b0;
    rank_wdata = rd_rank_q + IW'(1);
    if (upd_eval) begin
      if (rd_idx_q == slot_q) begin
        rank_we = 1'b1;
        rank_wdata = '0;
      end else if (rd_entry_valid && (rd_rank_q < old_rank_q)) begin
        rank_we = 1'b1;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    occ_d = occ_q;
    if (cmd_i.decide && alloc) begin
      valid_d[free_slot_q] = 1'b1;
      occ_d = occ_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      keys_mem[slot_d] <= key_q;
    end
    rd_key_q <= keys_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      vals_mem[slot_d] <= val_q;
    end
    rd_val_q <= vals_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rd_idx_q] <= rank_wdata;
    end
    rd_rank_q <= rank_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q <= '0;
      cap_q <= CAP_RESET;
      rd_vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      valid_q <= valid_d;
      occ_q <= occ_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= sts_o.idx_last ? '0 : idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (cmd_i.load) begin
      op_q <= operation_i;
      key_q <= key_i;
      val_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      free_found_q <= 1'b0;
      any_q <= 1'b0;
      evict_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
      free_found_q <= 1'b0;
      any_q <= 1'b0;
      evict_q <= 1'b0;
    end else begin
      if (scan_eval && rd_entry_valid && (rd_key_q == key_q)) begin
        hit_q <= 1'b1;
      end
      if (scan_eval && !rd_entry_valid) begin
        free_found_q <= 1'b1;
      end
      if (scan_eval && rd_entry_valid) begin
        any_q <= 1'b1;
      end
      if (cmd_i.decide) begin
        evict_q <= evict_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_eval && rd_entry_valid && (rd_key_q == key_q) && !hit_q) begin
      hit_slot_q <= rd_idx_q;
      hit_rank_q <= rd_rank_q;
      hit_val_q <= rd_val_q;
    end
    if (scan_eval && !rd_entry_valid && !free_found_q) begin
      free_slot_q <= rd_idx_q;
    end
    if (scan_eval && rd_entry_valid && (!any_q || (rd_rank_q > worst_q))) begin
      worst_q <= rd_rank_q;
      victim_slot_q <= rd_idx_q;
      victim_key_q <= rd_key_q;
    end
    if (cmd_i.decide) begin
      slot_q <= slot_d;
      old_rank_q <= old_rank_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_hit_q <= hit_q;
      out_read_q <= (hit_q && !is_put) ? hit_val_q : MISS_VALUE;
      out_evicted_q <= evict_q;
      out_evkey_q <= evict_q ? victim_key_q : '0;
    end
  end

  assign sts_o.idx_last = (idx_q == IW'(MAX_ENTRIES - 1));
  assign sts_o.need_update = hit_q || is_put;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign hit_o = out_hit_q;
  assign read_value_o = out_read_q;
  assign evicted_o = out_evicted_q;
  assign evicted_key_o = out_evkey_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q >= $past(occ_q))
    else $error("occupancy decreased");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(MAX_ENTRIES))
    else $error("occupancy exceeds the store size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_evicted_q))
    else $error("a hit reported an eviction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide && alloc) |=> $countones(valid_q) == $countones($past(valid_q)) + 1)
    else $error("allocation did not set exactly one valid bit");

endmodule

// ===== src/lru_key_value_cache.sv =====
// A get miss delivers its result after the lookup scan alone; a get hit or any put also runs
// the recency update pass first. A new transaction is taken only after the last one has
// finished. The lookup scan and the update pass each visit one entry per cycle through one
// memory port.
// Reset clears all valid bits and the occupancy count at once and sets capacity to 16.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [DATA_W-1:0] key_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [DATA_W-1:0] read_value_o,
  output logic              evicted_o,
  output logic [DATA_W-1:0] evicted_key_o
);

  cmd_t cmd;
  sts_t sts;

  lkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkv_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

endmodule
